// File: hdl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, codes and helpers for the two-level slot id allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int SLOT_W = 6;
    localparam int MAP_W  = 64;

    // operation codes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_CLAIM   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_USED     = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    localparam logic [MAP_W-1:0]  MAP_FULL       = {MAP_W{1'b1}};
    localparam logic [SLOT_W-1:0] NEW_GROUP_SLOT = 6'd63;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SLOT_W-1:0] group_number;
        logic [SLOT_W-1:0] slot_number;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] given_group;
        logic [SLOT_W-1:0] given_slot;
    } rsp_t;

    // one word of group flags covers 64 groups
    typedef struct packed {
        logic [MAP_W-1:0] present;
        logic [MAP_W-1:0] avail;    // present and not full
    } flag_word_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RD,
        S_WB
    } state_t;

    // what the write-back step does
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_NOSPACE,
        ACT_SCAN,
        ACT_REQ_FREE,
        ACT_REQ_NEW,
        ACT_CLAIM,
        ACT_RELEASE
    } act_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic clear_en;
        logic scan_rd;
        logic scan_eval;
        logic wb_fire;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t in_act;
        logic clear_last;
        logic scan_hit;
        logic scan_last;
        logic scan_absent;
        logic out_busy;
    } dp_status_t;

    // index of the lowest set bit; byte first, then bit within the byte
    function automatic logic [SLOT_W-1:0] lowest_set(input logic [MAP_W-1:0] v);
        logic [2:0] byte_idx;
        logic [2:0] bit_idx;
        logic [7:0] sel;
        byte_idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i*8 +: 8] != 8'd0)
            begin
                byte_idx = 3'(i);
            end
        end
        sel = v[{byte_idx, 3'b000} +: 8];
        bit_idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (sel[i])
            begin
                bit_idx = 3'(i);
            end
        end
        return {byte_idx, bit_idx};
    endfunction

endpackage

// File: hdl/tsa_ram.sv
// ----------------------------------------------------------------------------
// tsa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsa_ram #(
    parameter int WIDTH      = 64,
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_WIDTH-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [ADDR_WIDTH-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// Sequencer: clearing pass, flag scan, read and write-back steps.
// ----------------------------------------------------------------------------
module tsa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  tsa_pkg::dp_status_t    status,
    output logic                   req_ready,
    output tsa_pkg::ctrl_cmd_t     cmd
);

    tsa_pkg::state_t state_reg;
    tsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsa_pkg::S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = tsa_pkg::S_IDLE;
                end
            end
            tsa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (status.in_act)
                        tsa_pkg::ACT_SCAN:    state_next = tsa_pkg::S_SCAN_RD;
                        tsa_pkg::ACT_CLAIM:   state_next = tsa_pkg::S_RD;
                        tsa_pkg::ACT_RELEASE: state_next = tsa_pkg::S_RD;
                        default:              state_next = tsa_pkg::S_WB;
                    endcase
                end
            end
            tsa_pkg::S_SCAN_RD:
            begin
                state_next = tsa_pkg::S_SCAN_CHK;
            end
            tsa_pkg::S_SCAN_CHK:
            begin
                priority if (status.scan_hit)
                begin
                    state_next = tsa_pkg::S_RD;
                end
                else if (status.scan_last)
                begin
                    state_next = status.scan_absent ? tsa_pkg::S_RD : tsa_pkg::S_WB;
                end
                else
                begin
                    state_next = tsa_pkg::S_SCAN_RD;
                end
            end
            tsa_pkg::S_RD:
            begin
                state_next = tsa_pkg::S_WB;
            end
            tsa_pkg::S_WB:
            begin
                if (!status.out_busy)
                begin
                    state_next = tsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tsa_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = (state_reg == tsa_pkg::S_IDLE);
        cmd.accept     = req_ready && req_valid;
        cmd.scan_start = cmd.accept && (status.in_act == tsa_pkg::ACT_SCAN);
        cmd.clear_en   = (state_reg == tsa_pkg::S_CLEAR);
        cmd.scan_rd    = (state_reg == tsa_pkg::S_SCAN_RD);
        cmd.scan_eval  = (state_reg == tsa_pkg::S_SCAN_CHK);
        cmd.wb_fire    = (state_reg == tsa_pkg::S_WB) && !status.out_busy;
    end

endmodule

// File: hdl/tsa_datapath.sv
// ----------------------------------------------------------------------------
// tsa_datapath
// Flag and slot map memories, scan registers, update logic, result register.
// ----------------------------------------------------------------------------
module tsa_datapath #(
    parameter int GROUP_COUNT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsa_pkg::req_t        req_data,
    input  logic                 rsp_ready,
    input  tsa_pkg::ctrl_cmd_t   cmd,
    output tsa_pkg::dp_status_t  status,
    output logic                 rsp_valid,
    output tsa_pkg::rsp_t        rsp_data
);

    localparam int FLAG_WORDS = (GROUP_COUNT + 63) / 64;
    localparam int WORD_AW    = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;
    localparam int GW         = WORD_AW + tsa_pkg::SLOT_W;
    localparam int MAP_AW     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int LAST_BITS  = GROUP_COUNT - (FLAG_WORDS - 1) * 64;
    localparam int FW_W       = $bits(tsa_pkg::flag_word_t);
    localparam logic [tsa_pkg::MAP_W-1:0] LAST_MASK =
        {tsa_pkg::MAP_W{1'b1}} >> (tsa_pkg::MAP_W - LAST_BITS);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(FLAG_WORDS - 1);

    // registers
    tsa_pkg::req_t        req_reg,          req_next;
    tsa_pkg::act_t        act_reg,          act_next;
    logic [GW-1:0]        target_reg,       target_next;
    logic [WORD_AW-1:0]   scan_cnt_reg,     scan_cnt_next;
    logic [WORD_AW-1:0]   clr_cnt_reg,      clr_cnt_next;
    logic                 absent_found_reg, absent_found_next;
    logic [GW-1:0]        absent_grp_reg,   absent_grp_next;
    logic                 rsp_valid_reg,    rsp_valid_next;
    tsa_pkg::rsp_t        rsp_reg,          rsp_next;

    // memories
    tsa_pkg::flag_word_t         flag_rd;
    tsa_pkg::flag_word_t         flag_new;
    tsa_pkg::flag_word_t         flag_wdata;
    logic                        flag_we;
    logic [WORD_AW-1:0]          flag_waddr;
    logic [WORD_AW-1:0]          flag_raddr;
    logic [tsa_pkg::MAP_W-1:0]   map_rd;
    logic [tsa_pkg::MAP_W-1:0]   new_map;
    logic                        upd_we;
    logic                        map_we;

    // scan
    logic [tsa_pkg::MAP_W-1:0]   word_mask;
    logic [tsa_pkg::MAP_W-1:0]   avail_bits;
    logic [tsa_pkg::MAP_W-1:0]   absent_bits;
    logic                        cur_absent;
    logic                        grp_ok;
    tsa_pkg::act_t               in_act;

    // write-back
    logic [tsa_pkg::SLOT_W-1:0]  wb_bit;
    logic                        present_b;
    logic [tsa_pkg::MAP_W-1:0]   cur_map;
    logic [tsa_pkg::MAP_W-1:0]   slot_mask;
    logic [tsa_pkg::SLOT_W-1:0]  free_slot;
    tsa_pkg::rsp_t               wb_rsp;

    tsa_ram #(
        .WIDTH (FW_W),
        .DEPTH (FLAG_WORDS)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (flag_rd)
    );

    tsa_ram #(
        .WIDTH (tsa_pkg::MAP_W),
        .DEPTH (GROUP_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (target_reg[MAP_AW-1:0]),
        .wdata (new_map),
        .raddr (target_reg[MAP_AW-1:0]),
        .rdata (map_rd)
    );

    // decode of the incoming request
    always_comb
    begin
        grp_ok = (32'(req_data.group_number) < 32'(GROUP_COUNT));
        unique case (req_data.operation)
            tsa_pkg::OP_REQUEST: in_act = tsa_pkg::ACT_SCAN;
            tsa_pkg::OP_CLAIM:   in_act = grp_ok ? tsa_pkg::ACT_CLAIM : tsa_pkg::ACT_NOSPACE;
            tsa_pkg::OP_RELEASE: in_act = grp_ok ? tsa_pkg::ACT_RELEASE : tsa_pkg::ACT_NONE;
            default:             in_act = tsa_pkg::ACT_NONE;
        endcase
    end

    // flag word seen during the scan; groups past the end never count as absent
    always_comb
    begin
        word_mask   = (scan_cnt_reg == LAST_WORD) ? LAST_MASK : {tsa_pkg::MAP_W{1'b1}};
        avail_bits  = flag_rd.avail & word_mask;
        absent_bits = ~flag_rd.present & word_mask;
        cur_absent  = |absent_bits;
    end

    // write-back update
    always_comb
    begin
        wb_bit    = target_reg[tsa_pkg::SLOT_W-1:0];
        present_b = flag_rd.present[wb_bit];
        cur_map   = present_b ? map_rd : '0;
        slot_mask = tsa_pkg::MAP_W'(1) << req_reg.slot_number;
        free_slot = tsa_pkg::lowest_set(~cur_map);
        new_map   = cur_map;
        upd_we    = 1'b0;
        wb_rsp    = '{status: tsa_pkg::ST_OK, given_group: '0, given_slot: '0};
        unique case (act_reg)
            tsa_pkg::ACT_REQ_FREE:
            begin
                new_map            = cur_map | (tsa_pkg::MAP_W'(1) << free_slot);
                upd_we             = 1'b1;
                wb_rsp.given_group = target_reg[tsa_pkg::SLOT_W-1:0];
                wb_rsp.given_slot  = free_slot;
            end
            tsa_pkg::ACT_REQ_NEW:
            begin
                new_map            = tsa_pkg::MAP_W'(1) << tsa_pkg::NEW_GROUP_SLOT;
                upd_we             = 1'b1;
                wb_rsp.given_group = target_reg[tsa_pkg::SLOT_W-1:0];
                wb_rsp.given_slot  = tsa_pkg::NEW_GROUP_SLOT;
            end
            tsa_pkg::ACT_CLAIM:
            begin
                if ((cur_map & slot_mask) != '0)
                begin
                    wb_rsp.status = tsa_pkg::ST_USED;
                end
                else
                begin
                    new_map = cur_map | slot_mask;
                    upd_we  = 1'b1;
                end
            end
            tsa_pkg::ACT_RELEASE:
            begin
                new_map = cur_map & ~slot_mask;
                upd_we  = present_b;
            end
            tsa_pkg::ACT_NOSPACE:
            begin
                wb_rsp.status = tsa_pkg::ST_NO_SPACE;
            end
            default:
            begin
                wb_rsp.status = tsa_pkg::ST_OK;
            end
        endcase

        flag_new                = flag_rd;
        flag_new.present[wb_bit] = 1'b1;
        flag_new.avail[wb_bit]   = (new_map != tsa_pkg::MAP_FULL);

        map_we     = cmd.wb_fire && upd_we;
        flag_we    = cmd.clear_en || map_we;
        flag_waddr = cmd.clear_en ? clr_cnt_reg : target_reg[GW-1:tsa_pkg::SLOT_W];
        flag_wdata = cmd.clear_en ? '0 : flag_new;
        flag_raddr = cmd.scan_rd ? scan_cnt_reg : target_reg[GW-1:tsa_pkg::SLOT_W];
    end

    // next values
    always_comb
    begin
        req_next          = req_reg;
        act_next          = act_reg;
        target_next       = target_reg;
        scan_cnt_next     = scan_cnt_reg;
        clr_cnt_next      = clr_cnt_reg;
        absent_found_next = absent_found_reg;
        absent_grp_next   = absent_grp_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;

        if (cmd.clear_en)
        begin
            clr_cnt_next = clr_cnt_reg + WORD_AW'(1);
        end

        if (cmd.accept)
        begin
            req_next    = req_data;
            act_next    = in_act;
            target_next = GW'(req_data.group_number);
        end

        if (cmd.scan_start)
        begin
            scan_cnt_next     = '0;
            absent_found_next = 1'b0;
        end

        if (cmd.scan_eval)
        begin
            priority if (|avail_bits)
            begin
                target_next = {scan_cnt_reg, tsa_pkg::lowest_set(avail_bits)};
                act_next    = tsa_pkg::ACT_REQ_FREE;
            end
            else if (scan_cnt_reg == LAST_WORD)
            begin
                priority if (absent_found_reg)
                begin
                    target_next = absent_grp_reg;
                    act_next    = tsa_pkg::ACT_REQ_NEW;
                end
                else if (cur_absent)
                begin
                    target_next = {scan_cnt_reg, tsa_pkg::lowest_set(absent_bits)};
                    act_next    = tsa_pkg::ACT_REQ_NEW;
                end
                else
                begin
                    act_next = tsa_pkg::ACT_NOSPACE;
                end
            end
            else
            begin
                if (!absent_found_reg && cur_absent)
                begin
                    absent_found_next = 1'b1;
                    absent_grp_next   = {scan_cnt_reg, tsa_pkg::lowest_set(absent_bits)};
                end
                scan_cnt_next = scan_cnt_reg + WORD_AW'(1);
            end
        end

        if (cmd.wb_fire)
        begin
            rsp_next       = wb_rsp;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg          <= tsa_pkg::ACT_NONE;
            scan_cnt_reg     <= '0;
            clr_cnt_reg      <= '0;
            absent_found_reg <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            act_reg          <= act_next;
            scan_cnt_reg     <= scan_cnt_next;
            clr_cnt_reg      <= clr_cnt_next;
            absent_found_reg <= absent_found_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        target_reg     <= target_next;
        absent_grp_reg <= absent_grp_next;
        rsp_reg        <= rsp_next;
    end

    always_comb
    begin
        status.in_act      = in_act;
        status.clear_last  = (clr_cnt_reg == LAST_WORD);
        status.scan_hit    = |avail_bits;
        status.scan_last   = (scan_cnt_reg == LAST_WORD);
        status.scan_absent = absent_found_reg || cur_absent;
        status.out_busy    = rsp_valid_reg && !rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// File: hdl/two_level_slot_id_allocator.sv
// ----------------------------------------------------------------------------
// two_level_slot_id_allocator
// Hands out, claims and releases ids made of a group and a slot 0..63.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives exactly one result. A claim or a
// release goes through acceptance, a slot map read and write-back; an unused
// operation or an out-of-range claim goes from acceptance to write-back. A new-id
// request scans the group flags one word of 64 groups at a time, each word read
// through the registered read port of the flag memory and then checked, stopping
// at the first word holding a present group that is not full; it then reads the
// slot map and writes back, with at most ceil(GROUP_COUNT/64) words looked at.
// A new-id request that finds no space looks at every word and skips the read.
// The result sits in an output register; the block goes back to accepting once
// the write-back has loaded it, and holds the write-back only while a previous
// result still waits. After reset a clearing pass wipes the flag memory, one
// word after another, with req_ready low.
// ----------------------------------------------------------------------------
module two_level_slot_id_allocator #(
    parameter int GROUP_COUNT = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tsa_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tsa_pkg::rsp_t  rsp_data
);

    // command and status between sequencer and datapath
    tsa_pkg::ctrl_cmd_t  cmd;
    tsa_pkg::dp_status_t status;

    // sequencer: clearing, flag scan, read, write-back
    tsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    // flag words (present / not-full per group), slot maps, result register
    tsa_datapath #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    // a request in progress blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous one in progress");

    // write-back never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb_fire |-> !(rsp_valid && !rsp_ready))
        else $error("result overwritten before taken");

    // no request taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> !req_ready)
        else $error("request accepted during clearing");

    // only a new-id request returns a group and slot; checked here for slot-used results
    a_used_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status == tsa_pkg::ST_USED)) |->
        ((rsp_data.given_group == '0) && (rsp_data.given_slot == '0)))
        else $error("claim result carries an id");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the two-level slot id allocator. Requests go in over a
// valid/ready channel. A ledger keeps its own copy of the group flags and
// slot maps, works out the expected response for every accepted request,
// and compares each response field by field, in order. There is a directed
// part first, then random traffic, a drain, a few directed requests, then
// more random traffic.
// ----------------------------------------------------------------------------
module tb_top;

    import tsa_pkg::*;

    localparam int GROUP_CNT = 64;

    // the one operation value the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Ledger: predicted allocator state and responses still to come
    // ------------------------------------------------------------------------
    class id_ledger;
        bit             group_live [GROUP_CNT];
        bit [MAP_W-1:0] slot_map   [GROUP_CNT];
        rsp_t           due_rsp    [$];
        int             mismatches;

        function rsp_t answer_for(req_t r);
            rsp_t a;
            int   g;
            int   s;
            bit   done;
            a    = '0;
            done = 1'b0;
            case (r.operation)
                OP_REQUEST:
                begin
                    // lowest present group with a free slot
                    for (g = 0; g < GROUP_CNT && !done; g++)
                    begin
                        if (group_live[g] && slot_map[g] != MAP_FULL)
                        begin
                            s = 0;
                            while (s < 63 && slot_map[g][s])
                                s++;
                            slot_map[g][s] = 1'b1;
                            a.given_group  = SLOT_W'(g);
                            a.given_slot   = SLOT_W'(s);
                            done           = 1'b1;
                        end
                    end
                    // otherwise open the lowest absent group at the top slot
                    for (g = 0; g < GROUP_CNT && !done; g++)
                    begin
                        if (!group_live[g])
                        begin
                            group_live[g]               = 1'b1;
                            slot_map[g]                 = '0;
                            slot_map[g][NEW_GROUP_SLOT] = 1'b1;
                            a.given_group               = SLOT_W'(g);
                            a.given_slot                = NEW_GROUP_SLOT;
                            done                        = 1'b1;
                        end
                    end
                    if (!done)
                        a.status = ST_NO_SPACE;
                end
                OP_CLAIM:
                begin
                    if (r.group_number >= GROUP_CNT)
                        a.status = ST_NO_SPACE;
                    else
                    begin
                        if (!group_live[r.group_number])
                        begin
                            group_live[r.group_number] = 1'b1;
                            slot_map[r.group_number]   = '0;
                        end
                        if (slot_map[r.group_number][r.slot_number])
                            a.status = ST_USED;
                        else
                            slot_map[r.group_number][r.slot_number] = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    if (r.group_number < GROUP_CNT && group_live[r.group_number])
                        slot_map[r.group_number][r.slot_number] = 1'b0;
                end
                default:
                begin
                end
            endcase
            return a;
        endfunction

        function void note_request(req_t r);
            due_rsp.push_back(answer_for(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (due_rsp.size() == 0)
            begin
                $error("response with none expected: status %0d group %0d slot %0d",
                       got.status, got.given_group, got.given_slot);
                mismatches++;
                return;
            end
            want = due_rsp.pop_front();
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.given_group !== want.given_group)
            begin
                $error("given_group mismatch: expected %0d, got %0d",
                       want.given_group, got.given_group);
                mismatches++;
            end
            if (got.given_slot !== want.given_slot)
            begin
                $error("given_slot mismatch: expected %0d, got %0d",
                       want.given_slot, got.given_slot);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block itself
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_data;

    id_ledger book;
    bit       idle_on;   // both sides may idle while this is set

    two_level_slot_id_allocator #(
        .GROUP_COUNT (GROUP_CNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Hard stop. Slowest honest run is well under a fifth of this: roughly
    // 660 requests, each with a full sender gap, a flag scan and a full
    // receiver stall.
    initial
    begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic req_t id_op(logic [1:0] op, logic [5:0] grp, logic [5:0] slot);
        req_t r;
        r.operation    = op;
        r.group_number = grp;
        r.slot_number  = slot;
        return r;
    endfunction

    // Look for an id the ledger holds as used; mostly in the low groups so
    // that claims and releases land where requests are busy.
    function automatic bit find_used_id(output logic [5:0] g, output logic [5:0] s);
        logic [5:0] gc;
        logic [5:0] sc;
        g = '0;
        s = '0;
        for (int tries = 0; tries < 16; tries++)
        begin
            gc = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
            if (book.group_live[gc] && book.slot_map[gc] != '0)
            begin
                sc = 6'($urandom_range(0, 63));
                while (!book.slot_map[gc][sc])
                    sc++;   // wraps at 64, and a set bit exists
                g = gc;
                s = sc;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic req_t random_item();
        req_t       r;
        int         pick;
        logic [5:0] g;
        logic [5:0] s;
        r    = id_op(OP_REQUEST, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.operation = OP_REQUEST;
        else if (pick < 65)
        begin
            // claim, often into the low groups to make holes and new groups
            r.operation = OP_CLAIM;
            if ($urandom_range(0, 1))
                r.group_number = 6'($urandom_range(0, 7));
        end
        else if (pick < 75)
        begin
            // claim of an id already out: slot-used answer
            r.operation = OP_CLAIM;
            if (find_used_id(g, s))
                r = id_op(OP_CLAIM, g, s);
        end
        else if (pick < 95)
        begin
            r.operation = OP_RELEASE;
            if ($urandom_range(0, 3) != 0 && find_used_id(g, s))
                r = id_op(OP_RELEASE, g, s);
        end
        else
            r.operation = OP_UNUSED;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Valid stays up across back-to-back requests; a gap, if
    // any, is inserted before the next request is presented.
    // ------------------------------------------------------------------------
    task automatic send_item(req_t r);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        book.note_request(r);
    endtask

    task automatic wait_drained();
        while (book.due_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side: check on each handshake, then pick next cycle's ready.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                book.check_response(rsp_data);
            if (idle_on && stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [5:0] g;
        logic [5:0] s;
        book    = new;
        idle_on = 1'b1;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty allocator first, so the first request opens group 0
        // at the top slot and the next one takes slot 0.
        send_item(id_op(OP_REQUEST, 6'd63, 6'd63));
        send_item(id_op(OP_REQUEST, 6'd0, 6'd0));
        send_item(id_op(OP_CLAIM, 6'd0, 6'd0));       // already used
        send_item(id_op(OP_CLAIM, 6'd63, 6'd63));     // opens top group
        send_item(id_op(OP_CLAIM, 6'd63, 6'd63));     // used
        send_item(id_op(OP_CLAIM, 6'd63, 6'd0));
        send_item(id_op(OP_RELEASE, 6'd63, 6'd63));
        send_item(id_op(OP_RELEASE, 6'd62, 6'd5));    // absent group
        send_item(id_op(OP_RELEASE, 6'd0, 6'd17));    // slot already free
        send_item(id_op(OP_UNUSED, 6'd63, 6'd63));
        send_item(id_op(OP_UNUSED, 6'd0, 6'd0));
        send_item(id_op(OP_REQUEST, 6'd0, 6'd63));
        send_item(id_op(OP_RELEASE, 6'd0, 6'd0));
        send_item(id_op(OP_REQUEST, 6'd21, 6'd42));   // reuses slot 0
        send_item(id_op(OP_CLAIM, 6'd1, 6'd1));       // group in the middle
        send_item(id_op(OP_REQUEST, 6'd42, 6'd21));
        send_item(id_op(OP_RELEASE, 6'd0, 6'd63));
        send_item(id_op(OP_REQUEST, 6'd0, 6'd0));     // lowest free, not top
        send_item(id_op(OP_CLAIM, 6'd0, 6'd62));
        send_item(id_op(OP_RELEASE, 6'd63, 6'd0));
        send_item(id_op(OP_REQUEST, 6'd63, 6'd0));

        // Random traffic; idling switched on and off in stretches
        for (int i = 0; i < 300; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            send_item(random_item());
        end

        // hold off until everything is back
        req_valid <= 1'b0;
        wait_drained();

        // A few directed requests on the populated state
        idle_on = 1'b1;
        send_item(id_op(OP_REQUEST, 6'd0, 6'd0));
        send_item(id_op(OP_REQUEST, 6'd63, 6'd63));
        void'(find_used_id(g, s));
        send_item(id_op(OP_CLAIM, g, s));
        send_item(id_op(OP_RELEASE, 6'd0, 6'd10));
        send_item(id_op(OP_REQUEST, 6'd5, 6'd5));     // lowest free slot again

        // Random traffic; last stretch with no idling
        for (int i = 0; i < 325; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (i >= 225)
                idle_on = 1'b0;
            send_item(random_item());
        end
        req_valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);   // catch any stray response
        if (book.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
